[rtl/dsv_pkg.sv]
package dsv_pkg;

   localparam int FIELD_W = 32;
   localparam int CSR_IDX_W = 8;

   typedef logic [0:0] op_type;
   localparam op_type OP_MUL = 1'b0;
   localparam op_type OP_DIV = 1'b1;

   typedef logic [1:0] reason_type;
   localparam reason_type RSN_OK = 2'd0;
   localparam reason_type RSN_RANGE = 2'd1;
   localparam reason_type RSN_MISMATCH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_P = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_ORDER_Q = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GENERATOR_G = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PUBLIC_KEY_Y = 8'd3;

   typedef struct packed {
      logic   go;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sts_type;

endpackage

[rtl/dsv_if.sv]
interface dsv_req_if import dsv_pkg::*;;
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] message_hash;
   logic [FIELD_W-1:0] sig_r;
   logic [FIELD_W-1:0] sig_s;
   modport source (output valid, message_hash, sig_r, sig_s, input ready);
   modport sink (input valid, message_hash, sig_r, sig_s, output ready);
endinterface

interface dsv_rsp_if import dsv_pkg::*;;
   logic       valid;
   logic       ready;
   logic       valid_res;
   reason_type reason;
   modport source (output valid, valid_res, reason, input ready);
   modport sink (input valid, valid_res, reason, output ready);
endinterface

interface dsv_csr_if import dsv_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [FIELD_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/dsv_arith.sv]
module dsv_arith import dsv_pkg::*; #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  logic [W-1:0] opa,
   input  logic [W-1:0] opb,
   input  logic [W-1:0] opm,
   output sts_type      sts,
   output logic [W-1:0] quo,
   output logic [W-1:0] rem
);

   localparam int CW = $clog2(W + 1);
   localparam logic [CW-1:0] LAST = CW'(W - 1);

   logic         busy_ff, busy_in, done_ff, done_in;
   op_type       op_ff, op_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0] acc_ff, acc_in, a_ff, a_in, b_ff, b_in, m_ff, m_in;
   logic [W:0]   dbl, dbl_r, sum, sum_r, rsh;

   always_comb begin
      dbl = {acc_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      sum = dbl_r + {1'b0, a_ff};
      sum_r = (sum >= {1'b0, m_ff}) ? sum - {1'b0, m_ff} : sum;
      rsh = {acc_ff, a_ff[W-1]};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      m_in = m_ff;
      if (cmd.go && !busy_ff) begin
         busy_in = 1'b1;
         op_in = cmd.op;
         cnt_in = '0;
         acc_in = '0;
         a_in = opa;
         b_in = opb;
         m_in = opm;
      end else if (busy_ff) begin
         if (op_ff == OP_MUL) begin
            acc_in = b_ff[W-1] ? sum_r[W-1:0] : dbl_r[W-1:0];
            b_in = {b_ff[W-2:0], 1'b0};
         end else begin
            if (rsh >= {1'b0, m_ff}) begin
               acc_in = W'(rsh - {1'b0, m_ff});
               a_in = {a_ff[W-2:0], 1'b1};
            end else begin
               acc_in = rsh[W-1:0];
               a_in = {a_ff[W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
      m_ff <= m_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quo = a_ff;
   assign rem = acc_ff;

endmodule

[rtl/dsa_signature_verify.sv]
// Channel | Direction | Contents
// req     | in        | message_hash, sig_r, sig_s
// rsp     | out       | valid_res, reason
// csr     | in        | index, data (modulus_p, group_order_q, generator_g, public_key_y)
// Each transaction is a sequence of passes of the shared bit-serial multiply/divide
// unit for the Euclid, reduction and square-and-multiply steps; a range reject is
// answered in the cycle after the request is taken.
// Reset is synchronous and restores the register defaults; no new request is taken
// until the response has been taken, and configuration writes are accepted whenever reset is low.
module dsa_signature_verify import dsv_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   dsv_req_if.sink   req,
   dsv_rsp_if.source rsp,
   dsv_csr_if.sink   csr
);

   localparam int W = WIDTH;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_EU_TEST = 5'd1;
   localparam logic [4:0] S_EU_DW = 5'd2;
   localparam logic [4:0] S_EU_MG = 5'd3;
   localparam logic [4:0] S_EU_MW = 5'd4;
   localparam logic [4:0] S_HQ_G = 5'd5;
   localparam logic [4:0] S_HQ_W = 5'd6;
   localparam logic [4:0] S_U1_G = 5'd7;
   localparam logic [4:0] S_U1_W = 5'd8;
   localparam logic [4:0] S_U2_G = 5'd9;
   localparam logic [4:0] S_U2_W = 5'd10;
   localparam logic [4:0] S_PB_G = 5'd11;
   localparam logic [4:0] S_PB_W = 5'd12;
   localparam logic [4:0] S_PE_TEST = 5'd13;
   localparam logic [4:0] S_PA_W = 5'd14;
   localparam logic [4:0] S_PS_G = 5'd15;
   localparam logic [4:0] S_PS_W = 5'd16;
   localparam logic [4:0] S_V1_G = 5'd17;
   localparam logic [4:0] S_V1_W = 5'd18;
   localparam logic [4:0] S_VQ_G = 5'd19;
   localparam logic [4:0] S_VQ_W = 5'd20;
   localparam logic [4:0] S_OUT = 5'd21;

   logic [4:0] state_ff, state_in;
   logic [FIELD_W-1:0] p_ff, q_ff, g_ff, y_ff;
   logic [W-1:0] p, q;
   logic [W-1:0] h_ff, h_in, r_ff, r_in;
   logic [W-1:0] x_ff, x_in, yy_ff, yy_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [W-1:0] t_ff, t_in, w_ff, w_in, u1_ff, u1_in, u2_ff, u2_in;
   logic [W-1:0] base_ff, base_in, e_ff, e_in, acc_ff, acc_in, pow1_ff, pow1_in;
   logic         sel_ff, sel_in;
   logic         rv_ff, rv_in, vres_ff, vres_in;
   reason_type   rsn_ff, rsn_in;
   cmd_type      cmd;
   sts_type      sts;
   logic [W-1:0] opa, opb, opm, quo, rem;

   assign p = W'(p_ff);
   assign q = W'(q_ff);

   dsv_arith #(.W(W)) u_arith (
      .clock(clock), .reset(reset), .cmd(cmd), .opa(opa), .opb(opb), .opm(opm),
      .sts(sts), .quo(quo), .rem(rem)
   );

   always_comb begin
      state_in = state_ff;
      h_in = h_ff; r_in = r_ff;
      x_in = x_ff; yy_in = yy_ff; c0_in = c0_ff; c1_in = c1_ff;
      t_in = t_ff; w_in = w_ff; u1_in = u1_ff; u2_in = u2_ff;
      base_in = base_ff; e_in = e_ff; acc_in = acc_ff; pow1_in = pow1_ff;
      sel_in = sel_ff;
      rv_in = rv_ff; vres_in = vres_ff; rsn_in = rsn_ff;
      cmd.go = 1'b0;
      cmd.op = OP_MUL;
      opa = '0; opb = '0; opm = q;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               h_in = W'(req.message_hash);
               r_in = W'(req.sig_r);
               if (W'(req.sig_r) == '0 || W'(req.sig_r) >= q ||
                   W'(req.sig_s) == '0 || W'(req.sig_s) >= q) begin
                  vres_in = 1'b0;
                  rsn_in = RSN_RANGE;
                  rv_in = 1'b1;
                  state_in = S_OUT;
               end else begin
                  x_in = q;
                  yy_in = W'(req.sig_s);
                  c0_in = '0;
                  c1_in = W'(1);
                  state_in = S_EU_TEST;
               end
            end
         end
         S_EU_TEST: begin
            if (yy_ff == '0) begin
               w_in = (x_ff == W'(1)) ? c0_ff : '0;
               state_in = S_HQ_G;
            end else begin
               cmd.go = 1'b1; cmd.op = OP_DIV;
               opa = x_ff; opm = yy_ff;
               state_in = S_EU_DW;
            end
         end
         S_EU_DW: begin
            if (sts.done) begin
               t_in = (quo >= q) ? quo - q : quo;
               x_in = yy_ff;
               yy_in = rem;
               state_in = S_EU_MG;
            end
         end
         S_EU_MG: begin
            cmd.go = 1'b1;
            opa = t_ff; opb = c1_ff;
            state_in = S_EU_MW;
         end
         S_EU_MW: begin
            if (sts.done) begin
               c0_in = c1_ff;
               c1_in = (c0_ff >= rem) ? c0_ff - rem : c0_ff - rem + q;
               state_in = S_EU_TEST;
            end
         end
         S_HQ_G: begin
            cmd.go = 1'b1; cmd.op = OP_DIV;
            opa = h_ff;
            state_in = S_HQ_W;
         end
         S_HQ_W: begin
            if (sts.done) begin
               h_in = rem;
               state_in = S_U1_G;
            end
         end
         S_U1_G: begin
            cmd.go = 1'b1;
            opa = h_ff; opb = w_ff;
            state_in = S_U1_W;
         end
         S_U1_W: begin
            if (sts.done) begin
               u1_in = rem;
               state_in = S_U2_G;
            end
         end
         S_U2_G: begin
            cmd.go = 1'b1;
            opa = r_ff; opb = w_ff;
            state_in = S_U2_W;
         end
         S_U2_W: begin
            if (sts.done) begin
               u2_in = rem;
               if (p < W'(2)) begin
                  t_in = '0;
                  state_in = S_VQ_G;
               end else begin
                  sel_in = 1'b0;
                  e_in = u1_ff;
                  acc_in = W'(1);
                  state_in = S_PB_G;
               end
            end
         end
         S_PB_G: begin
            cmd.go = 1'b1; cmd.op = OP_DIV;
            opa = sel_ff ? W'(y_ff) : W'(g_ff); opm = p;
            state_in = S_PB_W;
         end
         S_PB_W: begin
            if (sts.done) begin
               base_in = rem;
               state_in = S_PE_TEST;
            end
         end
         S_PE_TEST: begin
            if (e_ff == '0) begin
               if (!sel_ff) begin
                  pow1_in = acc_ff;
                  sel_in = 1'b1;
                  e_in = u2_ff;
                  acc_in = W'(1);
                  state_in = S_PB_G;
               end else begin
                  state_in = S_V1_G;
               end
            end else if (e_ff[0]) begin
               cmd.go = 1'b1;
               opa = acc_ff; opb = base_ff; opm = p;
               state_in = S_PA_W;
            end else begin
               state_in = S_PS_G;
            end
         end
         S_PA_W: begin
            if (sts.done) begin
               acc_in = rem;
               state_in = S_PS_G;
            end
         end
         S_PS_G: begin
            cmd.go = 1'b1;
            opa = base_ff; opb = base_ff; opm = p;
            state_in = S_PS_W;
         end
         S_PS_W: begin
            if (sts.done) begin
               base_in = rem;
               e_in = e_ff >> 1;
               state_in = S_PE_TEST;
            end
         end
         S_V1_G: begin
            cmd.go = 1'b1;
            opa = pow1_ff; opb = acc_ff; opm = p;
            state_in = S_V1_W;
         end
         S_V1_W: begin
            if (sts.done) begin
               t_in = rem;
               state_in = S_VQ_G;
            end
         end
         S_VQ_G: begin
            cmd.go = 1'b1; cmd.op = OP_DIV;
            opa = t_ff;
            state_in = S_VQ_W;
         end
         S_VQ_W: begin
            if (sts.done) begin
               vres_in = (rem == r_ff);
               rsn_in = (rem == r_ff) ? RSN_OK : RSN_MISMATCH;
               rv_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               rv_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
         p_ff <= 32'd23;
         q_ff <= 32'd11;
         g_ff <= 32'd5;
         y_ff <= 32'd1;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         if (csr.valid) begin
            case (csr.index)
               CSR_MODULUS_P: p_ff <= csr.data;
               CSR_GROUP_ORDER_Q: q_ff <= csr.data;
               CSR_GENERATOR_G: g_ff <= csr.data;
               CSR_PUBLIC_KEY_Y: y_ff <= csr.data;
               default: ;
            endcase
         end
      end
      h_ff <= h_in; r_ff <= r_in;
      x_ff <= x_in; yy_ff <= yy_in; c0_ff <= c0_in; c1_ff <= c1_in;
      t_ff <= t_in; w_ff <= w_in; u1_ff <= u1_in; u2_ff <= u2_in;
      base_ff <= base_in; e_ff <= e_in; acc_ff <= acc_in; pow1_ff <= pow1_in;
      sel_ff <= sel_in;
      vres_ff <= vres_in;
      rsn_ff <= rsn_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = rv_ff;
   assign rsp.valid_res = vres_ff;
   assign rsp.reason = rsn_ff;

`ifndef ASSERT_OFF
   a_rsp_in_out: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> state_ff == S_OUT)
      else $error("response valid outside the output state");
   a_req_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> state_ff != S_IDLE)
      else $error("accepted transaction did not start");
   a_pass_reason: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && vres_ff) |-> rsn_ff == RSN_OK)
      else $error("passing signature with a failure reason");
   a_unit_idle_go: assert property (@(posedge clock) disable iff (reset)
      cmd.go |-> !sts.busy)
      else $error("arithmetic unit started while busy");
`endif

endmodule
